/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/bpc_pkg.sv */
// types and constants of the button press classifier
package bpc_pkg;

    localparam int unsigned PIN_W   = 16;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned STATE_W = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PIN_W-1:0]   BUTTON_PIN_RST = 16'd1;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST = 16'd500;
    localparam logic [COUNT_W-1:0] WINDOW_RST     = 16'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_EDGE        = 2'd0,
        OP_TICK        = 2'd1,
        OP_CLEAR       = 2'd2,
        OP_RESET_COUNT = 2'd3
    } t_op;

    typedef enum logic [STATE_W-1:0] {
        PRESS_NONE   = 2'd0,
        PRESS_SINGLE = 2'd1,
        PRESS_DOUBLE = 2'd2,
        PRESS_LONG   = 2'd3
    } t_press;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_PIN    = 2'd0,
        CFG_LONG_LIMIT    = 2'd1,
        CFG_DOUBLE_WINDOW = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PIN_W-1:0]   button_pin;
        logic [LIMIT_W-1:0] long_press_limit;
        logic [COUNT_W-1:0] double_window;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [PIN_W-1:0]   event_pin;
        logic               pin_level;
        logic [STAMP_W-1:0] now_ms;
    } t_in_item;

endpackage

/* sv/bpc_in_if.sv */
// input channel of the button press classifier
interface bpc_in_if
    import bpc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [PIN_W-1:0]   event_pin;
    logic               pin_level;
    logic [STAMP_W-1:0] now_ms;

    modport source (output valid, output operation, output event_pin, output pin_level,
                    output now_ms, input ready);
    modport sink (input valid, input operation, input event_pin, input pin_level,
                  input now_ms, output ready);
endinterface

/* sv/bpc_out_if.sv */
// result channel of the button press classifier
interface bpc_out_if
    import bpc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] press_state;

    modport source (output valid, output press_state, input ready);
    modport sink (input valid, input press_state, output ready);
endinterface

/* sv/bpc_cfg_regs.sv */
// configuration registers of the button press classifier
module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUTTON_PIN:    n_cfg.button_pin       = i_cfg_wdata[PIN_W-1:0];
                CFG_LONG_LIMIT:    n_cfg.long_press_limit = i_cfg_wdata[LIMIT_W-1:0];
                CFG_DOUBLE_WINDOW: n_cfg.double_window    = i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_pin       <= BUTTON_PIN_RST;
            r_cfg.long_press_limit <= LONG_LIMIT_RST;
            r_cfg.double_window    <= WINDOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/bpc_in_reg.sv */
// input register stage of the button press classifier
module bpc_in_reg
    import bpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    bpc_in_if.sink   i_in,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    `include "assert_macros.svh"

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_load || (r_valid && !i_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.operation <= i_in.operation;
            r_item.event_pin <= i_in.event_pin;
            r_item.pin_level <= i_in.pin_level;
            r_item.now_ms    <= i_in.now_ms;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // a held transaction is never lost
    `ASSERT_CLK(a_held_kept, i_clk, i_rst_n, r_valid && !i_take |=> r_valid, "in_reg: held transaction dropped")
    // a take only happens on a held transaction
    `ASSERT_CLK(a_take_valid, i_clk, i_rst_n, i_take |-> r_valid, "in_reg: take without transaction")

endmodule

/* sv/bpc_core.sv */
// classifier state update and result register
module bpc_core
    import bpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_take,
    bpc_out_if.source o_out
);

    `include "assert_macros.svh"

    logic [STAMP_W-1:0] r_press_stamp;
    logic [STAMP_W-1:0] n_press_stamp;
    logic               r_awaiting;
    logic               n_awaiting;
    logic [COUNT_W-1:0] r_window_count;
    logic [COUNT_W-1:0] n_window_count;
    t_press             r_reported;
    t_press             n_reported;
    logic               r_out_valid;
    t_press             r_out_state;

    logic               w_fire;
    logic [STAMP_W-1:0] w_held;
    logic [COUNT_W-1:0] w_count_inc;

    assign w_fire      = i_valid && (!r_out_valid || o_out.ready);
    assign o_take      = w_fire;
    assign w_held      = i_item.now_ms - r_press_stamp;
    assign w_count_inc = (r_window_count != COUNT_MAX) ? r_window_count + 1'b1 : r_window_count;

    always_comb begin
        n_press_stamp  = r_press_stamp;
        n_awaiting     = r_awaiting;
        n_window_count = r_window_count;
        n_reported     = r_reported;
        if (w_fire) begin
            case (t_op'(i_item.operation))
                OP_EDGE: begin
                    if (i_item.event_pin == i_cfg.button_pin) begin
                        if (!i_item.pin_level) begin
                            n_press_stamp = i_item.now_ms;
                        end else begin
                            n_window_count = '0;
                            if (w_held > {{(STAMP_W-LIMIT_W){1'b0}}, i_cfg.long_press_limit}) begin
                                n_reported = PRESS_LONG;
                            end else if (r_awaiting) begin
                                n_reported = PRESS_DOUBLE;
                                n_awaiting = 1'b0;
                            end else begin
                                n_awaiting = 1'b1;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (r_awaiting) begin
                        n_window_count = w_count_inc;
                        if (w_count_inc > i_cfg.double_window) begin
                            n_reported = PRESS_SINGLE;
                            n_awaiting = 1'b0;
                        end
                    end
                end
                OP_CLEAR:       n_reported = PRESS_NONE;
                OP_RESET_COUNT: n_window_count = '0;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_stamp  <= '0;
            r_awaiting     <= 1'b0;
            r_window_count <= '0;
            r_reported     <= PRESS_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            r_press_stamp  <= n_press_stamp;
            r_awaiting     <= n_awaiting;
            r_window_count <= n_window_count;
            r_reported     <= n_reported;
            r_out_valid    <= w_fire || (r_out_valid && !o_out.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_state <= n_reported;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.press_state = r_out_state;

    // result carries the state left by its transaction
    `ASSERT_CLK(a_result_state, i_clk, i_rst_n, w_fire |=> r_out_valid && r_out_state == r_reported, "core: result differs from held state")
    // state only moves on a transaction
    `ASSERT_CLK(a_state_frozen, i_clk, i_rst_n, !w_fire |=> $stable(r_window_count) && $stable(r_awaiting) && $stable(r_reported), "core: state changed without transaction")
    // a fresh single press always ends the wait
    `ASSERT_CLK(a_single_ends_wait, i_clk, i_rst_n, w_fire && n_reported == PRESS_SINGLE && r_reported != PRESS_SINGLE |=> !r_awaiting, "core: single press left wait open")
    // a fresh double press always ends the wait
    `ASSERT_CLK(a_double_ends_wait, i_clk, i_rst_n, w_fire && n_reported == PRESS_DOUBLE && r_reported != PRESS_DOUBLE |=> !r_awaiting, "core: double press left wait open")

endmodule

/* sv/button_press_classifier_top.sv */
// top level of the button press classifier
// Classifies a push button as single, double or long press from pin edge, tick, clear and
// counter reset transactions; every accepted transaction gives exactly one result holding the
// reported press state. An input register and a result register bracket the combinational
// update logic, so a transaction can be accepted every cycle while results are taken. An
// accepted transaction is held in the input register, and its result is then loaded into the
// result register, from which it is taken. With the result side stalled the two registers
// fill and the input is held off. The 32-bit held-time subtract and compare sets the path
// length. Registers are to be written through i_cfg_we / i_cfg_idx / i_cfg_wdata only while no
// transaction is in flight, which the block itself does not enforce; index 3 is ignored.
module button_press_classifier_top
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    bpc_in_if.sink                i_in,
    bpc_out_if.source             o_out
);

    t_cfg     w_cfg;
    logic     w_valid;
    logic     w_take;
    t_in_item w_item;

    bpc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    bpc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_item  (w_item)
    );

    bpc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_out   (o_out)
    );

endmodule
